// File: src/buoda_pkg.sv
// Shared types, constants and the unstuffing step for the order decoder.
package buoda_pkg;

  localparam int unsigned RawBits     = 64;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned NumStages   = RawBits / ByteW;
  localparam int unsigned PayloadBits = 49;
  localparam int unsigned PosW        = 6;
  localparam int unsigned OnesW       = 3;
  localparam int unsigned RunLimit    = 5;
  localparam int unsigned SumW        = 63;
  localparam int unsigned AmountW     = 16;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QPtrW       = 2;
  localparam int unsigned QCntW       = 3;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // Unstuffing state carried from stage to stage
  typedef struct packed {
    logic [PayloadBits-1:0] payload;
    logic [PosW-1:0]        pos;
    logic [OnesW-1:0]       ones;
    logic                   skip;
  } ustate_t;

  // One decoded order travelling from the front to the back
  typedef struct packed {
    logic        start;
    logic [7:0]  price;
    logic [7:0]  quantity;
    logic        is_sell;
    logic [31:0] stock_id;
  } order_t;

  localparam ustate_t UStateInit = '{payload: '0, pos: '0, ones: '0, skip: 1'b0};

  // Consume eight raw bits, LSB first
  function automatic ustate_t step_byte(ustate_t s, logic [ByteW-1:0] b);
    ustate_t r;
    r = s;
    for (int j = 0; j < ByteW; j++) begin
      if (r.pos != PosW'(PayloadBits)) begin
        if (r.skip) begin
          r.skip = 1'b0;
        end else if (b[j]) begin
          r.payload[r.pos] = 1'b1;
          r.pos = r.pos + PosW'(1);
          if (r.ones == OnesW'(RunLimit - 1)) begin
            r.ones = '0;
            r.skip = 1'b1;
          end else begin
            r.ones = r.ones + OnesW'(1);
          end
        end else begin
          r.ones = '0;
          r.pos  = r.pos + PosW'(1);
        end
      end
    end
    return r;
  endfunction

endpackage

// File: src/buoda_unstuff.sv
// Front end: eight-stage unstuffing pipeline, one raw byte per stage.
module buoda_unstuff (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [buoda_pkg::RawBits-1:0] raw_i,
  input  logic                          start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output buoda_pkg::order_t             out_item_o
);

  logic                          adv;
  logic [buoda_pkg::NumStages-1:0] v_q;
  buoda_pkg::ustate_t            st_q    [buoda_pkg::NumStages];
  logic                          start_q [buoda_pkg::NumStages];
  logic [buoda_pkg::RawBits-1:0] raw_q   [buoda_pkg::NumStages-1];

  // Whole pipe moves together; it halts only when the last stage is blocked
  assign adv        = !v_q[buoda_pkg::NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[buoda_pkg::NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0]    <= buoda_pkg::step_byte(buoda_pkg::UStateInit, raw_i[buoda_pkg::ByteW-1:0]);
      start_q[0] <= start_i;
      raw_q[0]   <= raw_i;
    end
  end

  for (genvar k = 1; k < buoda_pkg::NumStages; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k]    <= buoda_pkg::step_byte(st_q[k-1],
                        raw_q[k-1][k*buoda_pkg::ByteW +: buoda_pkg::ByteW]);
        start_q[k] <= start_q[k-1];
      end
    end
    if (k < buoda_pkg::NumStages - 1) begin : g_raw
      always_ff @(posedge clk_i) begin
        if (adv) begin
          raw_q[k] <= raw_q[k-1];
        end
      end
    end
  end

  assign out_valid_o         = v_q[buoda_pkg::NumStages-1];
  assign out_item_o.start    = start_q[buoda_pkg::NumStages-1];
  assign out_item_o.stock_id = st_q[buoda_pkg::NumStages-1].payload[31:0];
  assign out_item_o.is_sell  = st_q[buoda_pkg::NumStages-1].payload[32];
  assign out_item_o.quantity = st_q[buoda_pkg::NumStages-1].payload[40:33];
  assign out_item_o.price    = st_q[buoda_pkg::NumStages-1].payload[48:41];

endmodule

// File: src/buoda_queue.sv
// Short queue of decoded orders between the front and back ends.
module buoda_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  buoda_pkg::order_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output buoda_pkg::order_t pop_item_o
);

  buoda_pkg::order_t             mem_q [buoda_pkg::QDepth];
  logic [buoda_pkg::QPtrW-1:0]   wptr_q, rptr_q;
  logic [buoda_pkg::QCntW-1:0]   cnt_q;
  logic                          push, pop;

  assign push_ready_o = cnt_q != buoda_pkg::QCntW'(buoda_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + buoda_pkg::QPtrW'(1);
      if (pop)  rptr_q <= rptr_q + buoda_pkg::QPtrW'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + buoda_pkg::QCntW'(1);
        2'b01:   cnt_q <= cnt_q - buoda_pkg::QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_item_i;
  end

endmodule

// File: src/buoda_accum.sv
// Back end: multiply stage, then saturating accumulate into the output register.
module buoda_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  buoda_pkg::order_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output buoda_pkg::order_t             out_item_o,
  output logic [buoda_pkg::AmountW-1:0] amount_o,
  output logic [buoda_pkg::SumW-1:0]    total_o
);

  logic                          adv;
  logic                          mv_q, ov_q;
  buoda_pkg::order_t             m_item_q, o_item_q;
  logic [buoda_pkg::AmountW-1:0] m_amt_q, o_amt_q;
  logic [buoda_pkg::SumW-1:0]    sum_q, o_sum_q, sum_d, base;
  logic [buoda_pkg::SumW:0]      wide;

  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  // base never exceeds the max, so a carry out of 63 bits means overflow
  assign base  = m_item_q.start ? '0 : sum_q;
  assign wide  = {1'b0, base} + (buoda_pkg::SumW + 1)'(m_amt_q);
  assign sum_d = wide[buoda_pkg::SumW] ? buoda_pkg::SumMax : wide[buoda_pkg::SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q  <= 1'b0;
      ov_q  <= 1'b0;
      sum_q <= '0;
    end else if (adv) begin
      mv_q <= in_valid_i;
      ov_q <= mv_q;
      if (mv_q) sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_item_q <= in_item_i;
      m_amt_q  <= buoda_pkg::AmountW'(in_item_i.quantity) *
                  buoda_pkg::AmountW'(in_item_i.price);
      o_item_q <= m_item_q;
      o_amt_q  <= m_amt_q;
      o_sum_q  <= sum_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = o_item_q;
  assign amount_o    = o_amt_q;
  assign total_o     = o_sum_q;

endmodule

// File: src/bit_unstuff_order_decode_accumulate.sv
// Top level of the bit-unstuffing order decoder with running traded total.
// Each input word is a 64-bit bit-stuffed order, LSB first: after five ones
// in a row the next raw bit is dropped, until 49 payload bits are recovered
// (missing bits read as zero). The payload splits into stock id, side,
// quantity and price; amount = quantity * price is added to a 63-bit total
// that saturates at its maximum and restarts when tuser (start of book) is
// set on the word. The block takes one word per cycle when not stalled and
// returns one result word per input word, in order. Each word passes through
// eight unstuffing stages of eight raw bits each, the queue memory, a multiply
// stage and the accumulate/output register. The front and back stall
// independently through a four-entry queue.
module bit_unstuff_order_decode_accumulate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [63:0]   s_axis_tdata_i,   // raw_word[63:0]
  input  logic          s_axis_tuser_i,   // start_of_book
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] stock_id, [32] is_sell, [40:33] quantity, [48:41] price,
  // [64:49] amount, [127:65] total_traded
  output logic [127:0]  m_axis_tdata_o
);

  logic                          f_valid, f_ready;
  buoda_pkg::order_t             f_item;
  logic                          q_valid, q_ready;
  buoda_pkg::order_t             q_item;
  buoda_pkg::order_t             o_item;
  logic [buoda_pkg::AmountW-1:0] o_amount;
  logic [buoda_pkg::SumW-1:0]    o_total;

  // Front: unstuff and split fields
  buoda_unstuff u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .raw_i       (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  buoda_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Back: multiply and accumulate
  buoda_accum u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (o_item),
    .amount_o    (o_amount),
    .total_o     (o_total)
  );

  assign m_axis_tdata_o = {o_total, o_amount, o_item.price, o_item.quantity,
                           o_item.is_sell, o_item.stock_id};

  // Total always includes this word's amount
  a_total_ge_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (o_total >= buoda_pkg::SumW'(o_amount)))
    else $error("total below amount");

  // Amount stays aligned with the fields it came from
  a_amount_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(o_amount) == 32'(o_item.quantity) * 32'(o_item.price)))
    else $error("amount misaligned with fields");

  // A decoded word blocked by a full queue is held, not dropped
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !f_ready) |=> (f_valid && $stable(f_item)))
    else $error("front dropped a blocked word");

endmodule

// File: tb/sv/order_total_checker.sv
`timescale 1ns / 100ps
// Watches both streams of the order decoder, predicts each result and compares it.
module order_total_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [63:0]  s_tdata_i,
  input  logic         s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [127:0] m_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  // Same layout as the result word, lowest field last
  typedef struct packed {
    logic [buoda_pkg::SumW-1:0]    total;
    logic [buoda_pkg::AmountW-1:0] amount;
    logic [7:0]                    price;
    logic [7:0]                    quantity;
    logic                          is_sell;
    logic [31:0]                   stock_id;
  } order_result_t;

  order_result_t              expected_orders[$];
  logic [buoda_pkg::SumW-1:0] book_total;
  int                         fails;

  // Drop the bit after every run of five ones, up to the payload length
  function automatic logic [buoda_pkg::PayloadBits-1:0] unstuff_payload(
      input logic [buoda_pkg::RawBits-1:0] w);
    logic [buoda_pkg::PayloadBits-1:0] p;
    int pos;
    int run;
    int k;
    p   = '0;
    pos = 0;
    run = 0;
    k   = 0;
    while (k < buoda_pkg::RawBits && pos < buoda_pkg::PayloadBits) begin
      if (w[k]) begin
        p[pos] = 1'b1;
        pos++;
        run++;
        if (run == buoda_pkg::RunLimit) begin
          run = 0;
          k++;
        end
      end else begin
        run = 0;
        pos++;
      end
      k++;
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    order_result_t                     want;
    order_result_t                     got;
    logic [buoda_pkg::PayloadBits-1:0] pl;
    logic [buoda_pkg::SumW:0]          wide_sum;
    logic [buoda_pkg::SumW-1:0]        base;
    if (!rst_ni) begin
      expected_orders.delete();
      book_total   = '0;
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pl            = unstuff_payload(s_tdata_i);
        want.stock_id = pl[31:0];
        want.is_sell  = pl[32];
        want.quantity = pl[40:33];
        want.price    = pl[48:41];
        want.amount   = buoda_pkg::AmountW'(want.quantity) *
                        buoda_pkg::AmountW'(want.price);
        base          = s_tuser_i ? '0 : book_total;
        wide_sum      = {1'b0, base} + (buoda_pkg::SumW+1)'(want.amount);
        book_total    = wide_sum[buoda_pkg::SumW] ? buoda_pkg::SumMax
                                                  : wide_sum[buoda_pkg::SumW-1:0];
        want.total    = book_total;
        expected_orders.insert(expected_orders.size(), want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (expected_orders.size() == 0) begin
          report_mismatch("result word with no order waiting", 64'(got.stock_id), '0);
        end else begin
          want = expected_orders.pop_front();
          if (got.stock_id !== want.stock_id)
            report_mismatch("stock_id", 64'(got.stock_id), 64'(want.stock_id));
          if (got.is_sell !== want.is_sell)
            report_mismatch("is_sell", 64'(got.is_sell), 64'(want.is_sell));
          if (got.quantity !== want.quantity)
            report_mismatch("quantity", 64'(got.quantity), 64'(want.quantity));
          if (got.price !== want.price)
            report_mismatch("price", 64'(got.price), 64'(want.price));
          if (got.amount !== want.amount)
            report_mismatch("amount", 64'(got.amount), 64'(want.amount));
          if (got.total !== want.total)
            report_mismatch("total_traded", 64'(got.total), 64'(want.total));
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_orders.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the order decoder testbench: clock, reset, stimulus and verdict.
module tb_top;

  localparam int ItemsRandom = 800;
  localparam int CycleLimit  = 400000;  // generous bound for the watchdog
  localparam int DrainCycles = 40;      // covers the block's pipeline plus queue slack

  // Receiver stall patterns; each runs for a random stretch of cycles
  typedef enum int {StallNone, StallCoin, StallHeavy, StallPeriodic} stall_mode_e;
  // What the encoder puts in a stuffing slot
  typedef enum int {StuffZero, StuffOne, StuffRandom} stuff_kind_e;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [63:0]  s_tdata  = '0;
  logic         s_tuser  = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [127:0] m_tdata;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int          burst_left = 0;
  stall_mode_e stall_mode = StallNone;
  int          stall_left = 0;

  always #6 clk_i = ~clk_i;

  bit_unstuff_order_decode_accumulate i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // raw_word[63:0]
    .s_axis_tuser_i  (s_tuser),   // start_of_book
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // stock_id, is_sell, quantity, price, amount, total
  );

  order_total_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: switch between stall patterns so back-pressure hits every
  // pipeline phase, including long stretches with no stall at all.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  m_tready <= 1'b1;
      StallCoin:  m_tready <= 1'($urandom_range(0, 1));
      StallHeavy: m_tready <= ($urandom_range(0, 5) == 0);
      default:    m_tready <= ((stall_left % 4) != 0);
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pack fields into payload order: id low, then side, quantity, price
  function automatic logic [buoda_pkg::PayloadBits-1:0] make_order(
      input logic [31:0] id,
      input logic sell,
      input logic [7:0] qty,
      input logic [7:0] price);
    return {price, qty, sell, id};
  endfunction

  // Bit-stuff a payload into a raw word; unused raw bits above are random
  function automatic logic [63:0] stuff_order(
      input logic [buoda_pkg::PayloadBits-1:0] payload,
      input stuff_kind_e kind);
    logic [63:0] w;
    int r;
    int run;
    w   = {$urandom, $urandom};
    r   = 0;
    run = 0;
    for (int k = 0; k < buoda_pkg::PayloadBits; k++) begin
      w[r] = payload[k];
      r++;
      if (payload[k]) begin
        run++;
        if (run == buoda_pkg::RunLimit) begin
          run = 0;
          case (kind)
            StuffZero: w[r] = 1'b0;
            StuffOne:  w[r] = 1'b1;
            default:   w[r] = 1'($urandom_range(0, 1));
          endcase
          r++;
        end
      end else begin
        run = 0;
      end
    end
    return w;
  endfunction

  // Byte values weighted toward the extremes and dense ones
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hF8 | 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [buoda_pkg::PayloadBits-1:0] random_order();
    logic [31:0] id;
    id = $urandom;
    case ($urandom_range(0, 3))
      0:       id = id | (32'hFFFF << $urandom_range(0, 16));  // long runs of ones
      1:       id = id & $urandom;                             // sparse
      default: ;
    endcase
    return make_order(id, 1'($urandom_range(0, 1)), pick_byte(), pick_byte());
  endfunction

  // Present one word and hold it until accepted. Bursts of random length
  // are separated by random gaps; a zero gap keeps valid high throughout.
  task automatic send_word(input logic [63:0] w, input logic sob);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= sob;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop sending until every predicted result has come back
  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [63:0] w;
    logic        sob;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, stuffing-slot values, restart of the total
    send_word(64'h0, 1'b1);
    send_word('1, 1'b0);                                    // stuffing bits are ones
    send_word(stuff_order('1, StuffOne), 1'b0);
    send_word(stuff_order('1, StuffZero), 1'b0);
    send_word(stuff_order(make_order('0, 1'b0, 8'hFF, 8'hFF), StuffRandom), 1'b1);
    send_word(stuff_order(make_order('0, 1'b0, 8'hFF, 8'hFF), StuffRandom), 1'b0);
    send_word(stuff_order(make_order('1, 1'b1, 8'hFF, 8'h00), StuffOne), 1'b0);
    send_word(stuff_order(make_order('0, 1'b1, 8'h00, 8'hFF), StuffOne), 1'b0);
    send_word(stuff_order(make_order('1, 1'b1, 8'h01, 8'h01), StuffZero), 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'h0000_0000_0000_001F, 1'b0);              // stuffing slot holds zero
    send_word(64'h0000_0000_0000_003F, 1'b0);              // stuffing slot holds one
    send_word(64'h0000_0000_0000_007F, 1'b0);
    send_word(64'hF800_0000_0000_0000, 1'b0);              // run of ones ends at raw bit 63
    send_word(64'h8000_0000_0000_0001, 1'b1);
    send_word(stuff_order(make_order(32'h8000_0001, 1'b0, 8'h80, 8'h80), StuffRandom),
              1'b0);
    for (int n = 0; n < 4; n++) begin
      send_word(stuff_order(make_order($urandom, 1'b0, 8'hFF, 8'hFF), StuffRandom), 1'b0);
    end
    wait_drained();

    // Random: mostly well-formed stuffed orders, the rest raw noise
    for (int n = 0; n < ItemsRandom; n++) begin
      if (n == ItemsRandom / 2) wait_drained();
      sob = ($urandom_range(0, 39) == 0);
      case ($urandom_range(0, 7))
        0:       w = {$urandom, $urandom};
        1:       w = {$urandom, $urandom} | {$urandom, $urandom};  // dense ones
        2:       w = {$urandom, $urandom} & {$urandom, $urandom};  // sparse ones
        default: w = stuff_order(random_order(), stuff_kind_e'($urandom_range(0, 2)));
      endcase
      send_word(w, sob);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
